>>> hw/rtl/ops_pkg.sv
// Shared types, constants and register map of the overdue poll scheduler.
`default_nettype none
package ops_pkg;

    // Default number of cells in the chain.
    localparam int FEEDS_DEF = 4;
    // Only this many sources have a mask bit and an interval register.
    localparam int SRC_LIMIT = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [15:0] FAIL_MAX  = 16'hFFFF;
    localparam logic [2:0]  SHIFT_CAP = 3'd5;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_QUERY   = 2'd0;
    localparam logic [1:0] FUNC_REPORT  = 2'd1;
    localparam logic [1:0] FUNC_REFRESH = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_MASK  = 3'd0;
    localparam logic [2:0] REG_BASE  = 3'd1;
    localparam logic [2:0] REG_INTV0 = 3'd2;
    localparam logic [2:0] REG_INTV1 = 3'd3;
    localparam logic [2:0] REG_INTV2 = 3'd4;
    localparam logic [2:0] REG_INTV3 = 3'd5;

    localparam logic [3:0]  MASK_RST = 4'd0;
    localparam logic [16:0] BASE_RST = 17'd5000;
    localparam logic [31:0] INTV_RST = 32'd60000;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [1:0]  report_src;
        logic        fetch_ok;
    } in_t;

    typedef struct packed {
        logic        granted;
        logic [1:0]  chosen_src;
        logic [15:0] fail_count;
        logic [31:0] next_due_ms;
        logic [31:0] refresh_count;
    } out_t;

    // Configuration seen by every cell.
    typedef struct packed {
        logic [3:0]                  mask;
        logic [16:0]                 base;
        logic [SRC_LIMIT-1:0][31:0] interval;
    } cfg_t;

    // Token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic        vld;
        logic [1:0]  func;
        logic [31:0] now;
        logic [1:0]  src;
        logic        ok;
        logic        found;
        logic [1:0]  best;
        logic [31:0] worst;
        logic [15:0] fails;
        logic [31:0] due;
    } tok_t;

endpackage
`default_nettype wire

>>> hw/rtl/ops_cell.sv
// One scheduler cell: holds one source's due time and failure count.
`default_nettype none
module ops_cell #(
    parameter int IDX = 0
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire ops_pkg::cfg_t cfg,
    input  wire ops_pkg::tok_t tok_in,
    output ops_pkg::tok_t      tok_out
);
    import ops_pkg::*;

    localparam bit         LIVE = (IDX < SRC_LIMIT);
    localparam logic [1:0] ID2  = 2'(IDX);

    logic [31:0] due_reg, due_next;
    logic [15:0] fail_reg, fail_next;
    tok_t        tok_reg, tok_next;

    logic        reg_bit;
    logic [31:0] intv;
    logic [31:0] diff;
    logic [15:0] cnt_inc;
    logic [2:0]  sh;
    logic [31:0] backoff;
    logic        hit;

    // Sources past the register map never take part in queries or reports.
    generate
        if (LIVE) begin : g_live
            assign reg_bit = cfg.mask[IDX];
            assign intv    = cfg.interval[IDX];
        end else begin : g_dead
            assign reg_bit = 1'b0;
            assign intv    = 32'd0;
        end
    endgenerate

    assign diff    = tok_in.now - due_reg;
    assign cnt_inc = (fail_reg == FAIL_MAX) ? fail_reg : fail_reg + 16'd1;
    assign sh      = (cnt_inc > 16'(SHIFT_CAP)) ? SHIFT_CAP : cnt_inc[2:0];
    assign backoff = {15'd0, cfg.base} << sh;
    assign hit     = LIVE && (tok_in.src == ID2);

    always_comb begin
        tok_next  = tok_in;
        due_next  = due_reg;
        fail_next = fail_reg;
        if (tok_in.vld) begin
            case (tok_in.func)
                FUNC_QUERY: begin
                    if (reg_bit && !diff[31] && (!tok_in.found || diff > tok_in.worst)) begin
                        tok_next.found = 1'b1;
                        tok_next.worst = diff;
                        tok_next.best  = ID2;
                        tok_next.fails = fail_reg;
                        tok_next.due   = due_reg;
                    end
                end
                FUNC_REPORT: begin
                    if (hit) begin
                        if (tok_in.ok) begin
                            fail_next = 16'd0;
                            due_next  = tok_in.now + intv;
                        end else begin
                            fail_next = cnt_inc;
                            due_next  = tok_in.now + backoff;
                        end
                        tok_next.fails = fail_next;
                        tok_next.due   = due_next;
                    end
                end
                FUNC_REFRESH: begin
                    due_next = 32'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            due_reg  <= '0;
            fail_reg <= '0;
            tok_reg  <= '0;
        end else begin
            due_reg  <= due_next;
            fail_reg <= fail_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ops_csr.sv
// Configuration registers of the overdue poll scheduler behind an APB-style port.
`default_nettype none
module ops_csr (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ops_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ops_pkg::DATA_W-1:0] pwdata,
    output logic      [ops_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output ops_pkg::cfg_t                   cfg
);
    import ops_pkg::*;

    logic [3:0]  mask_reg;
    logic [16:0] base_reg;
    logic [31:0] intv_reg [SRC_LIMIT];
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= MASK_RST;
            base_reg <= BASE_RST;
            for (int i = 0; i < SRC_LIMIT; i++) begin
                intv_reg[i] <= INTV_RST;
            end
        end else if (wr) begin
            case (idx)
                REG_MASK:  mask_reg    <= pwdata[3:0];
                REG_BASE:  base_reg    <= pwdata[16:0];
                REG_INTV0: intv_reg[0] <= pwdata;
                REG_INTV1: intv_reg[1] <= pwdata;
                REG_INTV2: intv_reg[2] <= pwdata;
                REG_INTV3: intv_reg[3] <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MASK:  prdata = {28'd0, mask_reg};
            REG_BASE:  prdata = {15'd0, base_reg};
            REG_INTV0: prdata = intv_reg[0];
            REG_INTV1: prdata = intv_reg[1];
            REG_INTV2: prdata = intv_reg[2];
            REG_INTV3: prdata = intv_reg[3];
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        cfg.mask = mask_reg;
        cfg.base = base_reg;
        for (int i = 0; i < SRC_LIMIT; i++) begin
            cfg.interval[i] = intv_reg[i];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/overdue_poll_scheduler.sv
// Top level of the overdue poll scheduler: cell chain, result register and refresh counter.
//
// Usage. Each transaction on the s_ channel carries one request: a service query, an
// outcome report for one source, or a refresh of all due times. Every request gives
// exactly one result transaction on the m_ channel. A query grants the registered
// source that is most overdue at now_ms, with ties going to the lowest index; a report
// reschedules its source after a success or a failed fetch; a refresh makes every
// source due and bumps the refresh counter.
// Flow. The request travels down a chain of FEEDS cells, one cell per cycle, each
// cell holding one source. The token leaving the last cell is shaped into a result
// and loaded into the output register. s_ready is low from acceptance and rises in the
// same cycle in which that result reaches the output register, so only one request
// walks the chain at a time.
// Stalls. If the receiver holds m_ready low, the finished result waits in the output
// register and s_ready rises again so that a new request can walk the chain; its result
// is parked in a holding register until the output register is free.
// Reset. aresetn is synchronous and active low. It clears all due times, failure
// counts and the refresh counter, and loads the configuration reset values.
`default_nettype none
module overdue_poll_scheduler #(
    parameter int FEEDS = ops_pkg::FEEDS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire ops_pkg::in_t               s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output ops_pkg::out_t                   m_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ops_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ops_pkg::DATA_W-1:0] pwdata,
    output logic      [ops_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import ops_pkg::*;

    cfg_t        cfg;
    tok_t        tok [FEEDS+1];
    tok_t        tail;
    out_t        res;
    logic        accept;
    logic        out_free;
    logic [31:0] total_reg, total_next;
    logic        busy_reg;
    logic        m_valid_reg;
    out_t        m_data_reg;
    logic        pend_vld_reg;
    out_t        pend_reg;

    ops_csr u_csr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A request enters the head of the chain in the cycle it is accepted.
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_comb begin
        tok[0]       = '0;
        tok[0].vld   = accept;
        tok[0].func  = s_data.func;
        tok[0].now   = s_data.now_ms;
        tok[0].src   = s_data.report_src;
        tok[0].ok    = s_data.fetch_ok;
    end

    generate
        for (genvar i = 0; i < FEEDS; i++) begin : g_cell
            ops_cell #(.IDX(i)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cfg     (cfg),
                .tok_in  (tok[i]),
                .tok_out (tok[i+1])
            );
        end
    endgenerate

    assign tail = tok[FEEDS];

    // Shape the token leaving the last cell into a result.
    assign total_next = (tail.vld && tail.func == FUNC_REFRESH) ? total_reg + 32'd1 : total_reg;

    always_comb begin
        res               = '0;
        res.refresh_count = total_next;
        res.fail_count    = tail.fails;
        res.next_due_ms   = tail.due;
        case (tail.func)
            FUNC_QUERY: begin
                res.granted    = tail.found;
                res.chosen_src = tail.found ? tail.best : 2'd0;
            end
            FUNC_REPORT: begin
                res.chosen_src = tail.src;
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= '0;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            total_reg <= total_next;
            if (out_free) begin
                if (pend_vld_reg) begin
                    m_data_reg   <= pend_reg;
                    m_valid_reg  <= 1'b1;
                    pend_vld_reg <= 1'b0;
                    busy_reg     <= 1'b0;
                end else if (tail.vld) begin
                    m_data_reg  <= res;
                    m_valid_reg <= 1'b1;
                    busy_reg    <= 1'b0;
                end else begin
                    m_valid_reg <= 1'b0;
                    if (accept) begin
                        busy_reg <= 1'b1;
                    end
                end
            end else begin
                if (tail.vld) begin
                    pend_reg     <= res;
                    pend_vld_reg <= 1'b1;
                end
                if (accept) begin
                    busy_reg <= 1'b1;
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
